// ----- rtl/ffra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// shared codes and types of the first-fit region allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

   localparam logic [1:0] KIND_ALLOC  = 2'd0;
   localparam logic [1:0] KIND_FREE   = 2'd1;
   localparam logic [1:0] KIND_RESIZE = 2'd2;
   localparam logic [1:0] KIND_COUNT  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam int SIZE_W = 17;
   localparam int OFF_W  = 16;

   typedef struct packed {
      logic                start;
      logic [SIZE_W-1:0]   dividend;
      logic [SIZE_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [SIZE_W-1:0]   quotient;
   } div_rsp_type;

endpackage

// ----- rtl/ffra_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_divider
// restoring divider, one quotient bit per cycle; divisor zero gives zero
// ----------------------------------------------------------------------------
module ffra_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  ffra_pkg::div_req_type div_req,
   output ffra_pkg::div_rsp_type div_rsp
);

   localparam int W  = ffra_pkg::SIZE_W;
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      trial   = {rem_ff[W-1:0], quo_ff[W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff} && dvs_ff != '0) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = (dvs_ff == '0) ? '0 : quo_ff;

endmodule

// ----- rtl/first_fit_region_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// table of live regions in offset order, first-fit allocate, free, resize, count
// ----------------------------------------------------------------------------
// Requests arrive on req_ (tuser = kind, tdata = size, offset, unit); each
// request gives exactly one response item on rsp_ with status, allocated
// offset, element count and the used / free byte totals.
// The region table sits in one memory of MAX_REGIONS entries with a registered
// read. An item is handled one at a time by a sequencer: a scan reads the live
// entries one at a time (a read state and a check state per entry), then
// allocate and free shift the entries behind the hit by one place, again with
// a read state and a write state per entry. Count runs a 17-step bit-serial
// divide after the scan.
// csr_ writes the arena size; it is taken only while idle with no response held.
// After reset the table is empty, used bytes are zero, arena is 65536; there
// is no clearing pass since only live entries are read.
// The response waits in an output register while rsp_tready is low; the next
// request can be taken in the cycle after that register has been handed over.
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
   parameter int MAX_REGIONS = 32,
   parameter int ARENA_MAX   = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // req_size[16:0], region_offset[32:17], unit_bytes[49:33]
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status, alloc_offset, elem_count, used, free
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);

   localparam int SW = ffra_pkg::SIZE_W;
   localparam int OW = ffra_pkg::OFF_W;
   localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam logic [SW-1:0] ARENA_CAP =
      (ARENA_MAX > 65536) ? SW'(65536) : SW'(ARENA_MAX);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_RD      = 9'b000000010,
      S_CHK     = 9'b000000100,
      S_TAIL    = 9'b000001000,
      S_SHR_RD  = 9'b000010000,
      S_SHR_WR  = 9'b000100000,
      S_SHL_RD  = 9'b001000000,
      S_SHL_WR  = 9'b010000000,
      S_DIV     = 9'b100000000
   } state_type;

   // table memory: start and length in one word
   logic [OW+SW-1:0] mem [MAX_REGIONS];
   logic [OW+SW-1:0] rd_data_ff;
   logic [IW-1:0]    rd_addr;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   logic [OW+SW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   state_type     state_ff, state_in;
   logic [SW-1:0] arena_ff, arena_in;
   logic [SW-1:0] used_ff, used_in;
   logic [CW-1:0] live_ff, live_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] hit_ff, hit_in;
   logic [1:0]    kind_ff, kind_in;
   logic [SW-1:0] size_ff, size_in;
   logic [OW-1:0] off_ff, off_in;
   logic [SW-1:0] unit_ff, unit_in;
   logic [SW-1:0] prev_end_ff, prev_end_in;
   logic [SW-1:0] hit_len_ff, hit_len_in;
   logic [OW-1:0] hit_start_ff, hit_start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    st_ff, st_in;
   logic [OW-1:0] aoff_ff, aoff_in;
   logic [SW-1:0] cnt_ff, cnt_in;

   ffra_pkg::div_req_type div_req;
   ffra_pkg::div_rsp_type div_rsp;

   ffra_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic [SW-1:0] arena_eff;
   logic [OW-1:0] e_start;
   logic [SW-1:0] e_len;
   logic [SW-1:0] e_start_x;
   logic [SW:0]   end_sum;
   logic          gap_fit;

   assign arena_eff = (arena_ff > ARENA_CAP) ? ARENA_CAP : arena_ff;
   assign e_start   = rd_data_ff[OW+SW-1:SW];
   assign e_len     = rd_data_ff[SW-1:0];
   assign e_start_x = {1'b0, e_start};
   assign gap_fit   = (e_start_x >= prev_end_ff) && (e_start_x - prev_end_ff >= size_ff);

   always_comb begin
      state_in     = state_ff;
      arena_in     = arena_ff;
      used_in      = used_ff;
      live_in      = live_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      kind_in      = kind_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      unit_in      = unit_ff;
      prev_end_in  = prev_end_ff;
      hit_len_in   = hit_len_ff;
      hit_start_in = hit_start_ff;
      rsp_valid_in = rsp_valid_ff;
      st_in        = st_ff;
      aoff_in      = aoff_ff;
      cnt_in       = cnt_ff;
      rd_addr      = idx_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IW-1:0];
      wr_data      = '0;
      div_req      = '0;
      end_sum      = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (csr_valid && csr_ready) arena_in = csr_data;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !rsp_valid_ff) begin
               kind_in     = req_tuser;
               size_in     = req_tdata[16:0];
               off_in      = req_tdata[32:17];
               unit_in     = req_tdata[49:33];
               idx_in      = '0;
               prev_end_in = '0;
               st_in       = ffra_pkg::ST_OK;
               aoff_in     = '0;
               cnt_in      = '0;
               rd_addr     = '0;
               state_in    = S_RD;
               if (req_tuser == ffra_pkg::KIND_ALLOC) begin
                  if (req_tdata[16:0] == '0 || req_tdata[16:0] > arena_eff) begin
                     st_in = ffra_pkg::ST_NO_SPACE;
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else if (live_ff >= CW'(MAX_REGIONS)) begin
                     st_in = ffra_pkg::ST_FULL;
                     rsp_valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else if (live_ff == '0) begin
                     state_in = S_TAIL;
                  end
               end else if (live_ff == '0) begin
                  st_in = ffra_pkg::ST_NOT_FOUND;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         // read issued for idx last cycle; entry now in rd_data_ff
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            end_sum = {2'b0, e_start} + {1'b0, e_len};
            if (kind_ff == ffra_pkg::KIND_ALLOC) begin
               if (gap_fit) begin
                  hit_in = idx_ff;
                  hit_start_in = prev_end_ff[OW-1:0];
                  // shift entries idx..live-1 up by one, from the top
                  idx_in = live_ff;
                  state_in = S_SHR_RD;
               end else begin
                  prev_end_in = end_sum[SW-1:0];
                  idx_in = idx_ff + 1'b1;
                  rd_addr = IW'(idx_ff + 1'b1);
                  state_in = (idx_ff + 1'b1 == live_ff) ? S_TAIL : S_RD;
               end
            end else if (e_start == off_ff) begin
               hit_in = idx_ff;
               hit_len_in = e_len;
               hit_start_in = e_start;
               if (kind_ff == ffra_pkg::KIND_COUNT) begin
                  div_req.start = 1'b1;
                  div_req.dividend = e_len;
                  div_req.divisor = unit_ff;
                  state_in = S_DIV;
               end else if (kind_ff == ffra_pkg::KIND_FREE ||
                            size_ff == '0) begin
                  used_in = used_ff - e_len;
                  idx_in = idx_ff + 1'b1;
                  rd_addr = IW'(idx_ff + 1'b1);
                  state_in = S_SHL_RD;
               end else if (size_ff > e_len) begin
                  // need next start as limit
                  idx_in = idx_ff + 1'b1;
                  rd_addr = IW'(idx_ff + 1'b1);
                  prev_end_in = {1'b0, e_start};
                  hit_len_in = e_len;
                  state_in = S_TAIL;
               end else begin
                  wr_en = 1'b1;
                  wr_data = {e_start, size_ff};
                  used_in = used_ff - e_len + size_ff;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               rd_addr = IW'(idx_ff + 1'b1);
               if (idx_ff + 1'b1 == live_ff) begin
                  st_in = ffra_pkg::ST_NOT_FOUND;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         // allocate: tail hole; resize: growth check (rd_data_ff holds next)
         S_TAIL: begin
            if (kind_ff == ffra_pkg::KIND_ALLOC) begin
               if (arena_eff >= prev_end_ff && arena_eff - prev_end_ff >= size_ff) begin
                  wr_en = 1'b1;
                  wr_addr = live_ff[IW-1:0];
                  wr_data = {prev_end_ff[OW-1:0], size_ff};
                  aoff_in = prev_end_ff[OW-1:0];
                  live_in = live_ff + 1'b1;
                  used_in = used_ff + size_ff;
               end else begin
                  st_in = ffra_pkg::ST_NO_SPACE;
               end
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               end_sum = {1'b0, prev_end_ff} + {1'b0, size_ff};
               if (end_sum > ((idx_ff < live_ff) ? {2'b0, e_start} : {1'b0, arena_eff})) begin
                  st_in = ffra_pkg::ST_NO_SPACE;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = hit_ff[IW-1:0];
                  wr_data = {hit_start_ff, size_ff};
                  used_in = used_ff - hit_len_ff + size_ff;
               end
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SHR_RD: begin
            if (idx_ff == hit_ff) begin
               wr_en = 1'b1;
               wr_addr = hit_ff[IW-1:0];
               wr_data = {hit_start_ff, size_ff};
               aoff_in = hit_start_ff;
               live_in = live_ff + 1'b1;
               used_in = used_ff + size_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr = IW'(idx_ff - 1'b1);
               state_in = S_SHR_WR;
            end
         end
         S_SHR_WR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_data = rd_data_ff;
            idx_in = idx_ff - 1'b1;
            state_in = S_SHR_RD;
         end
         S_SHL_RD: begin
            if (idx_ff >= live_ff) begin
               live_in = live_ff - 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_SHL_WR;
            end
         end
         S_SHL_WR: begin
            wr_en = 1'b1;
            wr_addr = IW'(idx_ff - 1'b1);
            wr_data = rd_data_ff;
            idx_in = idx_ff + 1'b1;
            rd_addr = IW'(idx_ff + 1'b1);
            state_in = S_SHL_RD;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               cnt_in = div_rsp.quotient;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         arena_ff     <= SW'(65536);
         used_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         arena_ff     <= arena_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      kind_ff      <= kind_in;
      size_ff      <= size_in;
      off_ff       <= off_in;
      unit_ff      <= unit_in;
      prev_end_ff  <= prev_end_in;
      hit_len_ff   <= hit_len_in;
      hit_start_ff <= hit_start_in;
      st_ff        <= st_in;
      aoff_ff      <= aoff_in;
      cnt_ff       <= cnt_in;
   end

   logic [SW-1:0] free_b;
   assign free_b = (arena_eff > used_ff) ? arena_eff - used_ff : '0;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   // arena size feeds free bytes of a held response
   assign csr_ready  = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, free_b, used_ff, cnt_ff, aoff_ff, st_ff};

`ifndef SYNTHESIS
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CW'(MAX_REGIONS))
      else $error("live count above table depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("request taken while busy");
`endif

endmodule

// ----- bench/first_fit_region_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_tb
// randomized check of allocate, free, resize and count against a region table
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the region table and arena size, predicts
// every response when a request is accepted, and compares the response items
// in order. Directed corner requests come first, then random sequences over
// several arena sizes, with random stalls on both sides.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_tb;

   localparam int SLOTS = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [16:0] free_b;
      logic [16:0] used_b;
      logic [16:0] count;
      logic [15:0] where;
      logic [1:0]  status;
   } rsp_item_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [16:0] csr_data = '0;

   int  errors = 0;
   bit  quiet_tail = 0;
   bit  long_hold = 0;
   int  idle_cycles = 0;

   first_fit_region_allocator dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   task automatic report(input string what, input logic [16:0] got, input logic [16:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   class region_board;
      logic [15:0]  start_q[$];
      logic [16:0]  len_q[$];
      logic [16:0]  arena_reg = 17'd65536;
      logic [16:0]  in_use = '0;
      rsp_item_type pending[$];

      function int find(logic [15:0] off);
         for (int i = 0; i < start_q.size(); i++)
            if (start_q[i] == off) return i;
         return -1;
      endfunction

      function int unsigned arena();
         return (arena_reg > 17'd65536) ? 65536 : int'(arena_reg);
      endfunction

      function void drop(int idx);
         in_use -= len_q[idx];
         start_q.delete(idx);
         len_q.delete(idx);
      endfunction

      function void note_request(logic [1:0] kind, logic [16:0] sz,
                                 logic [15:0] off, logic [16:0] unit);
         rsp_item_type r;
         int f;
         int unsigned prev_end, lim, ar;
         bit done;
         r = '0;
         r.status = ffra_pkg::ST_OK;
         ar = arena();
         case (kind)
            ffra_pkg::KIND_ALLOC: begin
               if (sz == 0 || sz > ar) r.status = ffra_pkg::ST_NO_SPACE;
               else if (start_q.size() >= SLOTS) r.status = ffra_pkg::ST_FULL;
               else begin
                  prev_end = 0;
                  done = 0;
                  for (int i = 0; i < start_q.size() && !done; i++) begin
                     if (start_q[i] >= prev_end && start_q[i] - prev_end >= sz) begin
                        start_q.insert(i, prev_end[15:0]);
                        len_q.insert(i, sz);
                        done = 1;
                     end else prev_end = start_q[i] + len_q[i];
                  end
                  if (!done && ar >= prev_end && ar - prev_end >= sz) begin
                     start_q.push_back(prev_end[15:0]);
                     len_q.push_back(sz);
                     done = 1;
                  end
                  if (done) begin
                     in_use += sz;
                     r.where = prev_end[15:0];
                  end else r.status = ffra_pkg::ST_NO_SPACE;
               end
            end
            ffra_pkg::KIND_FREE: begin
               f = find(off);
               if (f < 0) r.status = ffra_pkg::ST_NOT_FOUND;
               else drop(f);
            end
            ffra_pkg::KIND_RESIZE: begin
               f = find(off);
               if (f < 0) r.status = ffra_pkg::ST_NOT_FOUND;
               else if (sz == 0) drop(f);
               else begin
                  lim = (f + 1 < start_q.size()) ? start_q[f+1] : ar;
                  if (sz > len_q[f] && start_q[f] + sz > lim)
                     r.status = ffra_pkg::ST_NO_SPACE;
                  else begin
                     in_use = in_use - len_q[f] + sz;
                     len_q[f] = sz;
                  end
               end
            end
            default: begin
               f = find(off);
               if (f < 0) r.status = ffra_pkg::ST_NOT_FOUND;
               else if (unit != 0) r.count = len_q[f] / unit;
            end
         endcase
         r.used_b = in_use;
         r.free_b = (ar > in_use) ? 17'(ar - in_use) : '0;
         pending.push_back(r);
      endfunction

      task check_response(logic [71:0] data);
         rsp_item_type got, want;
         got = data[$bits(rsp_item_type)-1:0];
         if (pending.size() == 0) begin
            report("unexpected item", '0, '0);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            report("status", 17'(got.status), 17'(want.status));
         if (got.where !== want.where)
            report("alloc_offset", 17'(got.where), 17'(want.where));
         if (got.count !== want.count) report("elem_count", got.count, want.count);
         if (got.used_b !== want.used_b) report("used_bytes", got.used_b, want.used_b);
         if (got.free_b !== want.free_b) report("free_bytes", got.free_b, want.free_b);
      endtask
   endclass

   region_board board = new();

   // accepted items on both sides and the cycle watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[16:0], req_tdata[32:17], req_tdata[49:33]);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, one long hold-off
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send(input logic [1:0] kind, input logic [16:0] sz,
                       input logic [15:0] off, input logic [16:0] unit);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, unit, off, sz};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_arena(input logic [16:0] v);
      csr_valid <= 1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      board.arena_reg = v;
   endtask

   // pick an offset of a live region most of the time
   function automatic logic [15:0] pick_off();
      if (board.start_q.size() != 0 && $urandom_range(0, 9) < 8)
         return board.start_q[$urandom_range(0, board.start_q.size() - 1)];
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic random_phase(input int items, input int unsigned max_sz);
      logic [1:0] k;
      logic [16:0] sz;
      logic [16:0] u;
      for (int i = 0; i < items; i++) begin
         k = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0:       sz = 17'($urandom_range(0, 131071));
            1:       sz = 17'($urandom_range(0, 65536));
            default: sz = 17'($urandom_range(1, max_sz));
         endcase
         u = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071)) :
                                          17'($urandom_range(0, 300));
         send(k, sz, pick_off(), u);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners
      send(ffra_pkg::KIND_ALLOC, 17'd0, 16'd0, 17'd1);
      send(ffra_pkg::KIND_ALLOC, 17'd65537, 16'd0, 17'd1);
      send(ffra_pkg::KIND_ALLOC, 17'h1FFFF, 16'd0, 17'd1);
      send(ffra_pkg::KIND_FREE, 17'd0, 16'd0, 17'd1);
      send(ffra_pkg::KIND_RESIZE, 17'd10, 16'hFFFF, 17'd1);
      send(ffra_pkg::KIND_COUNT, 17'd0, 16'd0, 17'd1);
      send(ffra_pkg::KIND_ALLOC, 17'd65536, 16'd0, 17'd1);
      send(ffra_pkg::KIND_COUNT, 17'd0, 16'd0, 17'h1FFFF);
      send(ffra_pkg::KIND_COUNT, 17'd0, 16'd0, 17'd0);
      send(ffra_pkg::KIND_COUNT, 17'd0, 16'd0, 17'd1);
      send(ffra_pkg::KIND_FREE, 17'd0, 16'd0, 17'd1);
      send(ffra_pkg::KIND_ALLOC, 17'd100, 16'd0, 17'd1);
      send(ffra_pkg::KIND_ALLOC, 17'd200, 16'd0, 17'd1);
      send(ffra_pkg::KIND_RESIZE, 17'd150, 16'd0, 17'd1);
      send(ffra_pkg::KIND_RESIZE, 17'd50, 16'd0, 17'd1);
      send(ffra_pkg::KIND_ALLOC, 17'd40, 16'd0, 17'd1);
      send(ffra_pkg::KIND_RESIZE, 17'd60, 16'd50, 17'd1);
      send(ffra_pkg::KIND_RESIZE, 17'd0, 16'd100, 17'd1);
      send(ffra_pkg::KIND_RESIZE, 17'd65436, 16'd0, 17'd1);
      for (int i = 0; i < 3; i++) send(ffra_pkg::KIND_ALLOC, 17'd1, 16'd0, 17'd1);
      drain();

      // fill the table while the receiver holds off
      long_hold = 1;
      for (int i = 0; i < 34; i++) send(ffra_pkg::KIND_ALLOC, 17'(1 + i), 16'd0, 17'd7);
      drain();

      // arena below live data, then extremes
      write_arena(17'd100);
      random_phase(100, 40);
      drain();
      write_arena(17'd1);
      send(ffra_pkg::KIND_ALLOC, 17'd1, 16'd0, 17'd1);
      random_phase(40, 3);
      drain();
      write_arena(17'h1FFFF);
      random_phase(300, 4000);
      drain();
      write_arena(17'd4096);
      random_phase(600, 300);
      drain();
      write_arena(17'd65536);
      random_phase(500, 8000);
      drain();
      quiet_tail = 1;
      random_phase(200, 3000);
      drain();

      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
